### src/kctr_pkg.sv
// Shared types, sizes and codes for the keyed counter table.
`default_nettype none
package kctr_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 5;
  localparam int KEY_W    = 16;
  localparam int AMT_W    = 16;
  localparam int CTR_W    = 32;
  localparam int STS_W    = 3;
  localparam int OP_W     = 2;

  localparam logic [CFG_W-1:0] CAP_RST = CFG_W'(16);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

  localparam logic [STS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STS_W-1:0] STS_FULL    = 3'd1;
  localparam logic [STS_W-1:0] STS_DUP     = 3'd2;
  localparam logic [STS_W-1:0] STS_UNKNOWN = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY   = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CTR_W-1:0] count;
  } ent_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [KEY_W-1:0] key;
    logic [CTR_W-1:0] count;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] cnt;
  } eng_stat_t;

endpackage
`default_nettype wire

### src/kctr_engine.sv
// Table memory and the sequencer that scans, updates, sorts and dumps it.
`default_nettype none
module kctr_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [kctr_pkg::OP_W-1:0] op,
  input  logic [kctr_pkg::KEY_W-1:0] key,
  input  logic [kctr_pkg::AMT_W-1:0] amount,
  input  logic [kctr_pkg::CNT_W-1:0] usable,
  input  logic                      out_free,
  output logic                      push,
  output kctr_pkg::res_t            res,
  output kctr_pkg::eng_stat_t       stat
);
  import kctr_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN_RD  = 4'd1;
  localparam logic [3:0] ST_SCAN_CHK = 4'd2;
  localparam logic [3:0] ST_EMIT     = 4'd3;
  localparam logic [3:0] ST_SORT_LD  = 4'd4;
  localparam logic [3:0] ST_SORT_LDW = 4'd5;
  localparam logic [3:0] ST_SORT_RD  = 4'd6;
  localparam logic [3:0] ST_SORT_CMP = 4'd7;
  localparam logic [3:0] ST_DUMP_RD  = 4'd8;
  localparam logic [3:0] ST_DUMP_EM  = 4'd9;

  ent_t mem [CAPACITY];
  ent_t rdata_r;

  logic [3:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [AMT_W-1:0] amt_r, amt_nxt;
  ent_t             cur_r, cur_nxt;
  res_t             pend_r, pend_nxt;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  ent_t             wdata;

  logic [CTR_W:0]   sum;
  logic [CTR_W-1:0] sat;
  logic [CTR_W-1:0] amt_ext;

  assign amt_ext = {{(CTR_W-AMT_W){amt_r[AMT_W-1]}}, amt_r};
  assign sum = {rdata_r.count[CTR_W-1], rdata_r.count} + {amt_ext[CTR_W-1], amt_ext};
  // clamp when the 33-bit sum leaves the 32-bit range
  assign sat = (sum[CTR_W] != sum[CTR_W-1]) ?
               (sum[CTR_W] ? {1'b1, {(CTR_W-1){1'b0}}} : {1'b0, {(CTR_W-1){1'b1}}}) :
               sum[CTR_W-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    i_nxt    = i_r;
    op_nxt   = op_r;
    key_nxt  = key_r;
    amt_nxt  = amt_r;
    cur_nxt  = cur_r;
    pend_nxt = pend_r;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = idx_r[IDX_W-1:0];
    raddr    = idx_r[IDX_W-1:0];
    wdata    = cur_r;
    push     = 1'b0;
    res      = pend_r;

    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = op;
          key_nxt = key;
          amt_nxt = amount;
          idx_nxt = '0;
          i_nxt   = '0;
          unique case (op)
            OP_INSERT: begin
              if (cnt_r >= usable) begin
                pend_nxt = '{STS_FULL, key, '0, 1'b1};
                st_nxt   = ST_EMIT;
              end else begin
                st_nxt = ST_SCAN_RD;
              end
            end
            OP_ADD: st_nxt = ST_SCAN_RD;
            OP_LOOKUP: begin
              if (cnt_r == '0) begin
                pend_nxt = '{STS_EMPTY, key, '0, 1'b1};
                st_nxt   = ST_EMIT;
              end else begin
                st_nxt = ST_SCAN_RD;
              end
            end
            OP_DUMP: begin
              priority if (cnt_r == '0) begin
                pend_nxt = '{STS_EMPTY, '0, '0, 1'b1};
                st_nxt   = ST_EMIT;
              end else if (cnt_r == CNT_W'(1)) begin
                st_nxt = ST_DUMP_RD;
              end else begin
                st_nxt = ST_SORT_LD;
              end
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          // key absent: insert appends, add and lookup report unknown
          if (op_r == OP_INSERT) begin
            we       = 1'b1;
            waddr    = cnt_r[IDX_W-1:0];
            wdata    = '{key_r, amt_ext};
            cnt_nxt  = cnt_r + CNT_W'(1);
            pend_nxt = '{STS_OK, key_r, amt_ext, 1'b1};
          end else begin
            pend_nxt = '{STS_UNKNOWN, key_r, '0, 1'b1};
          end
          st_nxt = ST_EMIT;
        end else begin
          re     = 1'b1;
          st_nxt = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (rdata_r.key == key_r) begin
          unique case (op_r)
            OP_INSERT: pend_nxt = '{STS_DUP, key_r, '0, 1'b1};
            OP_ADD: begin
              we       = 1'b1;
              wdata    = '{key_r, sat};
              pend_nxt = '{STS_OK, key_r, sat, 1'b1};
            end
            OP_LOOKUP: pend_nxt = '{STS_OK, key_r, rdata_r.count, 1'b1};
            default:   pend_nxt = '{STS_UNKNOWN, key_r, '0, 1'b1};
          endcase
          st_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          st_nxt  = ST_SCAN_RD;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          push   = 1'b1;
          st_nxt = ST_IDLE;
        end
      end

      ST_SORT_LD: begin
        re     = 1'b1;
        raddr  = i_r[IDX_W-1:0];
        st_nxt = ST_SORT_LDW;
      end

      ST_SORT_LDW: begin
        cur_nxt = rdata_r;
        idx_nxt = i_r + CNT_W'(1);
        st_nxt  = ST_SORT_RD;
      end

      ST_SORT_RD: begin
        if (idx_r == cnt_r) begin
          // inner pass done: position i holds its final entry
          we    = 1'b1;
          waddr = i_r[IDX_W-1:0];
          i_nxt = i_r + CNT_W'(1);
          if (i_r + CNT_W'(2) == cnt_r) begin
            idx_nxt = '0;
            st_nxt  = ST_DUMP_RD;
          end else begin
            st_nxt = ST_SORT_LD;
          end
        end else begin
          re     = 1'b1;
          st_nxt = ST_SORT_CMP;
        end
      end

      ST_SORT_CMP: begin
        if ($signed(cur_r.count) < $signed(rdata_r.count)) begin
          we      = 1'b1;
          cur_nxt = rdata_r;
        end
        idx_nxt = idx_r + CNT_W'(1);
        st_nxt  = ST_SORT_RD;
      end

      ST_DUMP_RD: begin
        re     = 1'b1;
        st_nxt = ST_DUMP_EM;
      end

      ST_DUMP_EM: begin
        res = '{STS_OK, rdata_r.key, rdata_r.count, (idx_r + CNT_W'(1) == cnt_r)};
        if (out_free) begin
          push = 1'b1;
          if (idx_r + CNT_W'(1) == cnt_r) begin
            st_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            st_nxt  = ST_DUMP_RD;
          end
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    idx_r  <= idx_nxt;
    i_r    <= i_nxt;
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    amt_r  <= amt_nxt;
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
  end

  assign stat.busy = (st_r != ST_IDLE);
  assign stat.cnt  = cnt_r;

endmodule
`default_nettype wire

### src/kctr_outreg.sv
// Output register that holds one result word until the sink takes it.
`default_nettype none
module kctr_outreg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kctr_pkg::res_t res,
  input  logic           out_stall,
  output logic           out_valid,
  output kctr_pkg::res_t out_res,
  output logic           free
);
  import kctr_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = push || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (push) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

### src/keyed_counter_table_ranked_top.sv
// Top level of the keyed counter table with ranked dump.
`default_nettype none
// Keyed counter table: up to 16 entries of {16-bit key, signed 32-bit counter}
// kept in one single-port synchronous RAM (one read or one write per cycle,
// registered read data). Operations: insert (0), saturating add (1),
// lookup (2) and ranked dump (3). One input word is taken at a time; in_stall
// stays high until its last result word is loaded into the output register.
// Each scanned entry takes a RAM read, then a compare. Insert, add and
// lookup scan from entry 0 until the key is found or all n entries have
// been checked; a full-table insert or an empty-table lookup or dump skips
// the scan. A dump runs the exchange sort with the current entry held in a
// register and one RAM read per compare when n is two or more, then reads
// and emits each word in turn. A stalled output holds the sequencer, not
// the table.
// capacity_limit (cfg_data) is clamped to 16; zero makes every insert report
// full. Write it only while idle.
module keyed_counter_table_ranked_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kctr_pkg::OP_W-1:0]         in_operation,
  input  logic [kctr_pkg::KEY_W-1:0]        in_key,
  input  logic signed [kctr_pkg::AMT_W-1:0] in_amount,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kctr_pkg::STS_W-1:0]        out_status,
  output logic [kctr_pkg::KEY_W-1:0]        out_key_out,
  output logic signed [kctr_pkg::CTR_W-1:0] out_count_out,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kctr_pkg::CFG_W-1:0]        cfg_data
);
  import kctr_pkg::*;

  logic [CFG_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] usable;
  logic             start;
  logic             push;
  logic             out_free;
  res_t             eng_res;
  res_t             out_res;
  eng_stat_t        stat;

  // config register: always ready, written only while idle by contract
  assign cfg_ready = 1'b1;
  assign cap_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RST;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // usable capacity: limit clamped to the physical table depth
  always_comb begin
    if (int'(cap_r) < CAPACITY) begin
      usable = CNT_W'(cap_r);
    end else begin
      usable = CNT_W'(CAPACITY);
    end
  end

  // sequencer takes a word only from idle
  assign in_stall = stat.busy;
  assign start    = in_valid && !in_stall;

  kctr_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .op       (in_operation),
    .key      (in_key),
    .amount   (in_amount),
    .usable   (usable),
    .out_free (out_free),
    .push     (push),
    .res      (eng_res),
    .stat     (stat)
  );

  kctr_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (eng_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .free      (out_free)
  );

  assign out_status    = out_res.status;
  assign out_key_out   = out_res.key;
  assign out_count_out = out_res.count;
  assign out_last      = out_res.last;

  // fill count never exceeds the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(stat.cnt) <= CAPACITY)
    else $error("entry count beyond table depth");

  // every accepted word makes the sequencer busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> stat.busy)
    else $error("accepted word did not start the sequencer");

  // sequencer never overwrites a result the sink has not taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && out_valid && out_stall))
    else $error("result pushed into a full output register");

endmodule
`default_nettype wire
